// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: character codes,
// result kinds and the classified byte that travels from front to back.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Default width of the chunk size counter.
  localparam int unsigned SIZE_BITS_DEF = 32;

  // Depth of the queue between front and back, and its index width.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // Character codes.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  // Offsets that map a letter digit straight onto its value (letter - 10).
  localparam logic [7:0] LO_OFFSET = 8'h57;
  localparam logic [7:0] UP_OFFSET = 8'h37;

  // Kind of a result transfer.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One input byte after classification by the front.
  typedef struct packed {
    logic [7:0] data;
    logic       sob;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

endpackage

// ===== design/hcbd_if.sv =====
// ----------------------------------------------------------------------------
// hcbd_in_if / hcbd_out_if
// Valid/ready channels of the chunked body decoder: raw body bytes in,
// payload bytes and status results out.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_body;

  modport source (output valid, output data_byte, output start_of_body, input ready);
  modport sink   (input valid, input data_byte, input start_of_body, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;

  modport source (output valid, output out_byte, output result_kind, input ready);
  modport sink   (input valid, input out_byte, input result_kind, output ready);
endinterface

// ===== design/hcbd_front.sv =====
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw body bytes and classifies each one (hex digit and its value,
// CR, LF) before it is queued for the parser.
// ----------------------------------------------------------------------------
module hcbd_front (
  hcbd_in_if.sink        in_i,
  output logic           push_valid_o,
  output hcbd_pkg::cls_t push_item_o,
  input  logic           push_ready_i
);

  logic [7:0] c;
  logic       is_dec;
  logic       is_lo;
  logic       is_up;

  assign c = in_i.data_byte;

  // Character ranges.
  assign is_dec = (c >= hcbd_pkg::CH_ZERO) && (c <= hcbd_pkg::CH_NINE);
  assign is_lo  = (c >= hcbd_pkg::CH_LO_A) && (c <= hcbd_pkg::CH_LO_F);
  assign is_up  = (c >= hcbd_pkg::CH_UP_A) && (c <= hcbd_pkg::CH_UP_F);

  // Build the classified item.
  always_comb begin
    push_item_o.data    = c;
    push_item_o.sob     = in_i.start_of_body;
    push_item_o.is_hex  = is_dec | is_lo | is_up;
    push_item_o.is_cr   = (c == hcbd_pkg::CH_CR);
    push_item_o.is_lf   = (c == hcbd_pkg::CH_LF);
    if (is_dec) begin
      push_item_o.hex_val = 4'(c - hcbd_pkg::CH_ZERO);
    end else if (is_lo) begin
      push_item_o.hex_val = 4'(c - hcbd_pkg::LO_OFFSET);
    end else if (is_up) begin
      push_item_o.hex_val = 4'(c - hcbd_pkg::UP_OFFSET);
    end else begin
      push_item_o.hex_val = 4'd0;
    end
  end

  // A transfer is taken whenever the queue has room.
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ===== design/hcbd_queue.sv =====
// ----------------------------------------------------------------------------
// hcbd_queue
// Two-entry queue of classified bytes between the front and the parser, so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module hcbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hcbd_pkg::cls_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output hcbd_pkg::cls_t pop_item_o
);

  localparam int unsigned CW = hcbd_pkg::QUEUE_AW + 1;

  hcbd_pkg::cls_t                    mem_q [hcbd_pkg::QUEUE_DEPTH];
  logic [hcbd_pkg::QUEUE_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hcbd_pkg::QUEUE_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                     count_q, count_d;
  logic                              push;
  logic                              pop;

  assign push_ready_o = (count_q != CW'(hcbd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/hcbd_back.sv =====
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk parser: walks the size line, the payload and the line breaks, and
// drives the result channel from an output register.
// ----------------------------------------------------------------------------
module hcbd_back #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  hcbd_pkg::cls_t  pop_item_i,
  hcbd_out_if.source      out_o
);

  typedef enum logic [7:0] {
    PH_SIZE    = 8'b0000_0001,
    PH_EXT     = 8'b0000_0010,
    PH_SIZE_LF = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_SKIP    = 8'b0001_0000,
    PH_FINAL   = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_e;

  localparam logic [SIZE_BITS-1:0] REM_ONE = SIZE_BITS'(1);

  phase_e                phase_q, phase_d, phase_cur;
  logic [SIZE_BITS-1:0]  rem_q, rem_d, rem_cur;
  logic                  seen_q, seen_d, seen_cur;
  logic                  skip_q, skip_d, skip_cur;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  hcbd_pkg::kind_e       out_kind_q, out_kind_d;

  logic                  pop;
  logic                  emit;
  logic                  fail;
  hcbd_pkg::kind_e       emit_kind;
  logic [7:0]            emit_byte;

  // An item leaves the queue whenever the output register is free or drains.
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // Start of body restarts the size line before the byte is parsed.
  always_comb begin
    if (pop_item_i.sob) begin
      phase_cur = PH_SIZE;
      rem_cur   = '0;
      seen_cur  = 1'b0;
      skip_cur  = 1'b0;
    end else begin
      phase_cur = phase_q;
      rem_cur   = rem_q;
      seen_cur  = seen_q;
      skip_cur  = skip_q;
    end
  end

  // Parser step for one byte.
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    seen_d    = seen_q;
    skip_d    = skip_q;
    emit      = 1'b0;
    fail      = 1'b0;
    emit_kind = hcbd_pkg::KIND_DATA;
    emit_byte = 8'd0;
    if (pop) begin
      phase_d = phase_cur;
      rem_d   = rem_cur;
      seen_d  = seen_cur;
      skip_d  = skip_cur;
      case (phase_cur)
        PH_SIZE: begin
          if (pop_item_i.is_hex) begin
            if (rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
              fail = 1'b1;
            end else begin
              rem_d  = {rem_cur[SIZE_BITS-5:0], pop_item_i.hex_val};
              seen_d = 1'b1;
            end
          end else if (!seen_cur) begin
            fail = 1'b1;
          end else begin
            phase_d = pop_item_i.is_cr ? PH_SIZE_LF : PH_EXT;
          end
        end
        PH_EXT: begin
          if (pop_item_i.is_cr) begin
            phase_d = PH_SIZE_LF;
          end
        end
        PH_SIZE_LF: begin
          if (pop_item_i.is_lf) begin
            skip_d  = 1'b0;
            phase_d = (rem_cur == '0) ? PH_FINAL : PH_DATA;
          end else if (!pop_item_i.is_cr) begin
            phase_d = PH_EXT;
          end
        end
        PH_DATA: begin
          rem_d     = rem_cur - REM_ONE;
          emit      = 1'b1;
          emit_byte = pop_item_i.data;
          if (rem_cur == REM_ONE) begin
            phase_d = PH_SKIP;
            skip_d  = 1'b0;
          end
        end
        PH_SKIP: begin
          // The two bytes after the payload are skipped unchecked.
          if (!skip_cur) begin
            skip_d = 1'b1;
          end else begin
            phase_d = PH_SIZE;
            rem_d   = '0;
            seen_d  = 1'b0;
            skip_d  = 1'b0;
          end
        end
        PH_FINAL: begin
          if (!skip_cur) begin
            if (!pop_item_i.is_cr) begin
              fail = 1'b1;
            end else begin
              skip_d = 1'b1;
            end
          end else if (!pop_item_i.is_lf) begin
            fail = 1'b1;
          end else begin
            phase_d   = PH_DONE;
            skip_d    = 1'b0;
            emit      = 1'b1;
            emit_kind = hcbd_pkg::KIND_DONE;
          end
        end
        default: begin
          // Done or error: bytes are dropped until the next start of body.
        end
      endcase
      if (fail) begin
        phase_d   = PH_ERROR;
        emit      = 1'b1;
        emit_kind = hcbd_pkg::KIND_ERROR;
        emit_byte = 8'd0;
      end
    end
  end

  // Output register next values.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    if (pop && emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_kind_d  = emit_kind;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      seen_q      <= seen_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.result_kind = out_kind_q;

endmodule

// ===== design/http_chunked_body_decoder_unit.sv =====
// The decoder takes one byte of a chunked HTTP body per clock while the
// output is not stalled and returns only the payload bytes, then a
// completion result after the closing empty line, or an error result on an
// empty or overflowing size line or a bad closing line break, after which
// it drops bytes until the next start of body. Each accepted byte gives at
// most one result; the byte passes through the queue into the parser, and
// the result is presented on the output from the output register. The
// parser's step in the back stage is combinational; a two-entry queue
// between the classifying front and the parser keeps input transfers
// flowing while a finished result waits at the output register.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Top level of the chunked transfer decoder: front classifier, queue and
// parser back end.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);

  logic           push_valid;
  logic           push_ready;
  hcbd_pkg::cls_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  hcbd_pkg::cls_t pop_item;

  // Byte classification.
  hcbd_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Decoupling queue.
  hcbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Chunk parser and result register.
  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

// ===== design/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] result_kind_i
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(result_kind_i))
    else $error("stalled result changed");

  // Only the three defined kinds are ever shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (result_kind_i == hcbd_pkg::KIND_DATA) ||
                    (result_kind_i == hcbd_pkg::KIND_DONE) ||
                    (result_kind_i == hcbd_pkg::KIND_ERROR))
    else $error("undefined result kind");

  // Status results carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != hcbd_pkg::KIND_DATA) |-> (out_byte_i == 8'd0))
    else $error("status result with non-zero byte");

  // Input back-pressure only follows an output stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back-pressure");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .result_kind_i (out_o.result_kind)
);
